// ===== hdl/bads_pkg.sv =====
// Package for the box-average image downscaler.
// Holds field widths, register indexes and reset values shared by the
// top level and its port checker; depends on nothing.
package bads_pkg;

   // Pixel and channel layout.
   localparam int PIXEL_W  = 8;
   localparam int CHANNELS = 3;
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // Widths of the configuration values and of the reduced-image position.
   localparam int FACTOR_W  = 5;
   localparam int AREA_W    = 2 * FACTOR_W;
   localparam int DIM_W     = 11;
   localparam int OUT_POS_W = 10;

   // Largest frame height the row counters support.
   localparam int MAX_HEIGHT = 1024;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [FACTOR_W-1:0] RESET_SCALE_FACTOR = 5'd2;
   localparam logic [DIM_W-1:0]    RESET_IMAGE_WIDTH  = 11'd640;
   localparam logic [DIM_W-1:0]    RESET_IMAGE_HEIGHT = 11'd480;

   typedef logic [PIXEL_W-1:0]                pixel_type;
   typedef logic [CHANNELS-1:0][PIXEL_W-1:0]  rgb_type;
   typedef logic [OUT_POS_W-1:0]              out_pos_type;

endpackage

// ===== hdl/box_average_downscale.sv =====
// Box-average downscaler: RGB pixels in raster order, one N by N block mean out.
// A block result passes the stage-two register, the divider and the result register.
// Throughput: one pixel per cycle unless stalled, set by the read-modify-write of the
// column sum memory; results leave through an eight-stage pipelined divider by N*N.
// Reset: synchronous; registers return to 2 / 640 / 480 and counters to frame start.
// The sum memory needs no clearing pass: the first pixel of every block loads its sum.
module box_average_downscale #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_FACTOR = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Pixel requests.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bads_pkg::pixel_type                 req_red_in,
   input  bads_pkg::pixel_type                 req_green_in,
   input  bads_pkg::pixel_type                 req_blue_in,
   // Averaged pixels.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bads_pkg::pixel_type                 rsp_red_avg,
   output bads_pkg::pixel_type                 rsp_green_avg,
   output bads_pkg::pixel_type                 rsp_blue_avg,
   output bads_pkg::out_pos_type               rsp_out_column,
   output bads_pkg::out_pos_type               rsp_out_row,
   output logic                                rsp_frame_last,
   // Configuration writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bads_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bads_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bads_pkg::*;

   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int SUM_W     = PIXEL_W + $clog2(MAX_FACTOR * MAX_FACTOR);
   localparam int DIV_W     = SUM_W + 1;
   localparam int QUOT_BITS = PIXEL_W;
   localparam int WIDE_W    = DIM_W + 2;

   typedef logic [CHANNELS-1:0][SUM_W-1:0] sums_type;
   typedef logic [CHANNELS-1:0][DIV_W-1:0] rems_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [FACTOR_W-1:0] scale_factor_ff, scale_factor_in;
   logic [DIM_W-1:0]    image_width_ff, image_width_in;
   logic [DIM_W-1:0]    image_height_ff, image_height_in;
   logic                csr_write;
   logic                restart;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // A write to a known register restarts the frame; unknown indexes are ignored.
   always_comb begin
      scale_factor_in = scale_factor_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      restart         = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SCALE_FACTOR: begin
               scale_factor_in = csr_data[FACTOR_W-1:0];
               restart         = 1'b1;
            end
            CSR_IMAGE_WIDTH: begin
               image_width_in = csr_data[DIM_W-1:0];
               restart        = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_data[DIM_W-1:0];
               restart         = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_factor_ff <= RESET_SCALE_FACTOR;
         image_width_ff  <= RESET_IMAGE_WIDTH;
         image_height_ff <= RESET_IMAGE_HEIGHT;
      end else begin
         scale_factor_ff <= scale_factor_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // Effective factor and frame size: zero acts as one, large values saturate.
   logic [FACTOR_W-1:0] factor;
   logic [FACTOR_W-1:0] factor_m1;
   logic [DIM_W-1:0]    width_lim;
   logic [DIM_W-1:0]    height_lim;
   logic [AREA_W-1:0]   area;

   always_comb begin
      if (scale_factor_ff == '0) begin
         factor = FACTOR_W'(1);
      end else if (32'(scale_factor_ff) > MAX_FACTOR) begin
         factor = FACTOR_W'(MAX_FACTOR);
      end else begin
         factor = scale_factor_ff;
      end
      if (image_width_ff == '0) begin
         width_lim = DIM_W'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         width_lim = DIM_W'(MAX_WIDTH);
      end else begin
         width_lim = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_lim = DIM_W'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         height_lim = DIM_W'(MAX_HEIGHT);
      end else begin
         height_lim = image_height_ff;
      end
   end

   assign factor_m1 = factor - FACTOR_W'(1);
   assign area      = AREA_W'(factor) * AREA_W'(factor);

   // ------------------------------------------------------------------
   // Raster position counters
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0]    col_cnt_ff, col_cnt_in;
   logic [OUT_POS_W-1:0] row_cnt_ff, row_cnt_in;
   logic [FACTOR_W-1:0]  col_in_blk_ff, col_in_blk_in;
   logic [FACTOR_W-1:0]  row_in_blk_ff, row_in_blk_in;
   logic [DIM_W-1:0]     blk_x_ff, blk_x_in;
   logic [DIM_W-1:0]     blk_y_ff, blk_y_in;

   logic                 req_fire;
   logic [WIDE_W-1:0]    x_end, y_end, x_next_end, y_next_end, x_pos, y_pos;
   logic                 blk_whole, blk_first, blk_last, blk_frame_last;
   logic                 row_end, frame_end;

   // Block geometry: x_end and y_end lie one past the current block.
   always_comb begin
      x_end          = WIDE_W'(blk_x_ff) + WIDE_W'(factor);
      y_end          = WIDE_W'(blk_y_ff) + WIDE_W'(factor);
      x_next_end     = x_end + WIDE_W'(factor);
      y_next_end     = y_end + WIDE_W'(factor);
      x_pos          = WIDE_W'(blk_x_ff) + WIDE_W'(col_in_blk_ff);
      y_pos          = WIDE_W'(blk_y_ff) + WIDE_W'(row_in_blk_ff);
      blk_whole      = (x_end <= WIDE_W'(width_lim)) && (y_end <= WIDE_W'(height_lim));
      blk_first      = (col_in_blk_ff == '0) && (row_in_blk_ff == '0);
      blk_last       = (col_in_blk_ff == factor_m1) && (row_in_blk_ff == factor_m1);
      blk_frame_last = (x_next_end > WIDE_W'(width_lim))
                       && (y_next_end > WIDE_W'(height_lim));
      row_end        = (x_pos + WIDE_W'(1)) >= WIDE_W'(width_lim);
      frame_end      = (y_pos + WIDE_W'(1)) >= WIDE_W'(height_lim);
   end

   // Return to frame start on a restart; else advance one pixel in raster order, wrapping at row and frame ends.
   always_comb begin
      col_cnt_in    = col_cnt_ff;
      row_cnt_in    = row_cnt_ff;
      col_in_blk_in = col_in_blk_ff;
      row_in_blk_in = row_in_blk_ff;
      blk_x_in      = blk_x_ff;
      blk_y_in      = blk_y_ff;
      if (restart) begin
         col_cnt_in    = '0;
         row_cnt_in    = '0;
         col_in_blk_in = '0;
         row_in_blk_in = '0;
         blk_x_in      = '0;
         blk_y_in      = '0;
      end else if (req_fire) begin
         if (row_end) begin
            col_cnt_in    = '0;
            col_in_blk_in = '0;
            blk_x_in      = '0;
            if (frame_end) begin
               row_cnt_in    = '0;
               row_in_blk_in = '0;
               blk_y_in      = '0;
            end else if (row_in_blk_ff == factor_m1) begin
               row_in_blk_in = '0;
               row_cnt_in    = row_cnt_ff + OUT_POS_W'(1);
               blk_y_in      = blk_y_ff + DIM_W'(factor);
            end else begin
               row_in_blk_in = row_in_blk_ff + FACTOR_W'(1);
            end
         end else if (col_in_blk_ff == factor_m1) begin
            col_in_blk_in = '0;
            col_cnt_in    = col_cnt_ff + ADDR_W'(1);
            blk_x_in      = blk_x_ff + DIM_W'(factor);
         end else begin
            col_in_blk_in = col_in_blk_ff + FACTOR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
         col_in_blk_ff <= '0;
         row_in_blk_ff <= '0;
         blk_x_ff      <= '0;
         blk_y_ff      <= '0;
      end else begin
         col_cnt_ff    <= col_cnt_in;
         row_cnt_ff    <= row_cnt_in;
         col_in_blk_ff <= col_in_blk_in;
         row_in_blk_ff <= row_in_blk_in;
         blk_x_ff      <= blk_x_in;
         blk_y_ff      <= blk_y_in;
      end
   end

   // ------------------------------------------------------------------
   // Column sum memory: read at accept; stage two adds the pixel and writes the sum later
   // ------------------------------------------------------------------
   sums_type sum_mem [MAX_WIDTH];
   sums_type rd_data_ff;

   logic                 s2_vld_ff, s2_vld_in;
   logic                 s2_whole_ff, s2_whole_in;
   logic                 s2_first_ff, s2_first_in;
   logic                 s2_last_ff, s2_last_in;
   logic                 s2_frm_last_ff, s2_frm_last_in;
   logic                 s2_bypass_ff, s2_bypass_in;
   logic [ADDR_W-1:0]    s2_addr_ff, s2_addr_in;
   logic [OUT_POS_W-1:0] s2_row_ff, s2_row_in;
   rgb_type              s2_pix_ff, s2_pix_in;
   sums_type             fwd_sum_ff, fwd_sum_in;

   sums_type             s2_base;
   sums_type             s2_sum;
   logic                 s2_push, s2_done, s2_write;
   logic [QUOT_BITS-1:0] dv_free;

   // The first pixel of a block loads its sum; a sum written in the same cycle
   // as the read is taken from the forwarding register.
   always_comb begin
      if (s2_first_ff) begin
         s2_base = '0;
      end else if (s2_bypass_ff) begin
         s2_base = fwd_sum_ff;
      end else begin
         s2_base = rd_data_ff;
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
         s2_sum[ch] = s2_base[ch] + SUM_W'(s2_pix_ff[ch]);
      end
   end

   assign s2_push   = s2_vld_ff && s2_whole_ff && s2_last_ff;
   assign s2_done   = s2_vld_ff && (!s2_push || dv_free[0]);
   assign s2_write  = s2_done && s2_whole_ff;
   assign req_ready = !s2_vld_ff || s2_done;
   assign req_fire  = req_valid && req_ready;

   // Capture the accepted request together with its block decode.
   always_comb begin
      s2_vld_in      = s2_vld_ff;
      s2_whole_in    = s2_whole_ff;
      s2_first_in    = s2_first_ff;
      s2_last_in     = s2_last_ff;
      s2_frm_last_in = s2_frm_last_ff;
      s2_bypass_in   = s2_bypass_ff;
      s2_addr_in     = s2_addr_ff;
      s2_row_in      = s2_row_ff;
      s2_pix_in      = s2_pix_ff;
      fwd_sum_in     = fwd_sum_ff;
      if (req_ready) begin
         s2_vld_in = req_fire;
      end
      if (req_fire) begin
         s2_whole_in    = blk_whole;
         s2_first_in    = blk_first;
         s2_last_in     = blk_last;
         s2_frm_last_in = blk_frame_last;
         s2_bypass_in   = s2_write && (s2_addr_ff == col_cnt_ff);
         s2_addr_in     = col_cnt_ff;
         s2_row_in      = row_cnt_ff;
         s2_pix_in[CH_RED]   = req_red_in;
         s2_pix_in[CH_GREEN] = req_green_in;
         s2_pix_in[CH_BLUE]  = req_blue_in;
      end
      if (s2_write) begin
         fwd_sum_in = s2_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_whole_ff    <= s2_whole_in;
      s2_first_ff    <= s2_first_in;
      s2_last_ff     <= s2_last_in;
      s2_frm_last_ff <= s2_frm_last_in;
      s2_bypass_ff   <= s2_bypass_in;
      s2_addr_ff     <= s2_addr_in;
      s2_row_ff      <= s2_row_in;
      s2_pix_ff      <= s2_pix_in;
      fwd_sum_ff     <= fwd_sum_in;
   end

   // Synchronous memory, read-first; the read data holds while stage two stalls.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= sum_mem[col_cnt_ff];
      end
      if (s2_write) begin
         sum_mem[s2_addr_ff] <= s2_sum;
      end
   end

   // ------------------------------------------------------------------
   // Pipelined restoring divider by N*N, one quotient bit per stage
   // ------------------------------------------------------------------
   logic [QUOT_BITS-1:0] dv_vld_ff, dv_vld_in;
   rems_type             dv_rem_ff [QUOT_BITS];
   rems_type             dv_rem_in [QUOT_BITS];
   rgb_type              dv_quot_ff [QUOT_BITS];
   rgb_type              dv_quot_in [QUOT_BITS];
   logic [ADDR_W-1:0]    dv_col_ff [QUOT_BITS];
   logic [ADDR_W-1:0]    dv_col_in [QUOT_BITS];
   logic [OUT_POS_W-1:0] dv_row_ff [QUOT_BITS];
   logic [OUT_POS_W-1:0] dv_row_in [QUOT_BITS];
   logic [QUOT_BITS-1:0] dv_last_ff, dv_last_in;

   rems_type             step_rem [QUOT_BITS];
   rgb_type              step_quot [QUOT_BITS];
   logic [DIV_W-1:0]     step_div [QUOT_BITS];

   logic                 rsp_valid_ff, rsp_valid_in;
   rgb_type              rsp_quot_ff, rsp_quot_in;
   logic [ADDR_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [OUT_POS_W-1:0] rsp_row_ff, rsp_row_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_free;

   // A stage may load when it is empty or its content moves on.
   always_comb begin
      rsp_free = !rsp_valid_ff || rsp_ready;
      dv_free[QUOT_BITS-1] = !dv_vld_ff[QUOT_BITS-1] || rsp_free;
      for (int k = QUOT_BITS - 2; k >= 0; k--) begin
         dv_free[k] = !dv_vld_ff[k] || dv_free[k+1];
      end
   end

   // Stage k settles quotient bit QUOT_BITS-1-k of every channel.
   always_comb begin
      for (int k = 0; k < QUOT_BITS; k++) begin
         step_div[k] = DIV_W'(area) << (QUOT_BITS - 1 - k);
         for (int ch = 0; ch < CHANNELS; ch++) begin
            step_rem[k][ch]  = dv_rem_ff[k][ch];
            step_quot[k][ch] = dv_quot_ff[k][ch];
            if (dv_rem_ff[k][ch] >= step_div[k]) begin
               step_rem[k][ch] = dv_rem_ff[k][ch] - step_div[k];
               step_quot[k][ch][QUOT_BITS-1-k] = 1'b1;
            end
         end
      end
   end

   // Move items down the divider and into the result register.
   always_comb begin
      dv_vld_in  = dv_vld_ff;
      dv_last_in = dv_last_ff;
      for (int k = 0; k < QUOT_BITS; k++) begin
         dv_rem_in[k]  = dv_rem_ff[k];
         dv_quot_in[k] = dv_quot_ff[k];
         dv_col_in[k]  = dv_col_ff[k];
         dv_row_in[k]  = dv_row_ff[k];
      end
      if (dv_free[0]) begin
         dv_vld_in[0]  = s2_push;
         dv_quot_in[0] = '0;
         dv_col_in[0]  = s2_addr_ff;
         dv_row_in[0]  = s2_row_ff;
         dv_last_in[0] = s2_frm_last_ff;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            dv_rem_in[0][ch] = DIV_W'(s2_sum[ch]);
         end
      end
      for (int k = 1; k < QUOT_BITS; k++) begin
         if (dv_free[k]) begin
            dv_vld_in[k]  = dv_vld_ff[k-1];
            dv_rem_in[k]  = step_rem[k-1];
            dv_quot_in[k] = step_quot[k-1];
            dv_col_in[k]  = dv_col_ff[k-1];
            dv_row_in[k]  = dv_row_ff[k-1];
            dv_last_in[k] = dv_last_ff[k-1];
         end
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_quot_in  = rsp_quot_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_free) begin
         rsp_valid_in = dv_vld_ff[QUOT_BITS-1];
         rsp_quot_in  = step_quot[QUOT_BITS-1];
         rsp_col_in   = dv_col_ff[QUOT_BITS-1];
         rsp_row_in   = dv_row_ff[QUOT_BITS-1];
         rsp_last_in  = dv_last_ff[QUOT_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dv_vld_ff    <= dv_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dv_rem_ff   <= dv_rem_in;
      dv_quot_ff  <= dv_quot_in;
      dv_col_ff   <= dv_col_in;
      dv_row_ff   <= dv_row_in;
      dv_last_ff  <= dv_last_in;
      rsp_quot_ff <= rsp_quot_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ------------------------------------------------------------------
   // Result ports
   // ------------------------------------------------------------------
   logic [ADDR_W+OUT_POS_W-1:0] col_wide;

   assign col_wide       = (ADDR_W + OUT_POS_W)'(rsp_col_ff);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_avg    = rsp_quot_ff[CH_RED];
   assign rsp_green_avg  = rsp_quot_ff[CH_GREEN];
   assign rsp_blue_avg   = rsp_quot_ff[CH_BLUE];
   assign rsp_out_column = col_wide[OUT_POS_W-1:0];
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

// ===== hdl/bads_check.sv =====
// Port-level checks for the box-average downscaler.
// Uses bads_pkg for port widths and is bound to box_average_downscale.
module bads_check (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input bads_pkg::pixel_type    rsp_red_avg,
   input bads_pkg::pixel_type    rsp_green_avg,
   input bads_pkg::pixel_type    rsp_blue_avg,
   input bads_pkg::out_pos_type  rsp_out_column,
   input bads_pkg::out_pos_type  rsp_out_row,
   input logic                   rsp_frame_last
);
   import bads_pkg::*;

   // Requests are refused only when the whole result path is backed up.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled while the result side can move");

   // Coming out of reset the block is empty and ready.
   assert property (@(posedge clock)
      $past(reset) |-> (req_ready && !rsp_valid))
      else $error("block not empty after reset");

   // A waiting result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_red_avg)
         && $stable(rsp_green_avg) && $stable(rsp_blue_avg)
         && $stable(rsp_out_column) && $stable(rsp_out_row)
         && $stable(rsp_frame_last)))
      else $error("stalled result changed");

endmodule

bind box_average_downscale bads_check u_bads_check (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_red_avg    (rsp_red_avg),
   .rsp_green_avg  (rsp_green_avg),
   .rsp_blue_avg   (rsp_blue_avg),
   .rsp_out_column (rsp_out_column),
   .rsp_out_row    (rsp_out_row),
   .rsp_frame_last (rsp_frame_last)
);
